/* src/rgmu_pkg.sv */
`timescale 1ns / 1ps

package rgmu_pkg;

  localparam int NUM_BITS  = 256;
  localparam int LOG_DEPTH = 4096;

  localparam int IDX_W  = 8;
  localparam int BIT_AW = $clog2(NUM_BITS);
  localparam int LOG_AW = $clog2(LOG_DEPTH);
  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int HC_W   = 13;
  localparam int TGT_W  = 13;
  localparam int CMP_W  = (CNT_W > TGT_W) ? CNT_W : TGT_W;
  localparam int LIM_W  = 9;

  localparam logic [LIM_W-1:0] LIM_RESET = 9'd256;

  typedef enum logic [1:0] {
    ACT_EXEC    = 2'd0,
    ACT_BACK    = 2'd1,
    ACT_FWD     = 2'd2,
    ACT_RESTORE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    GATE_CCNOT = 2'd0,
    GATE_CNOT  = 2'd1,
    GATE_NOT   = 2'd2,
    GATE_SWAP  = 2'd3
  } gate_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_LOG_FULL   = 3'd1,
    ST_NO_UNDO    = 3'd2,
    ST_NO_REDO    = 3'd3,
    ST_BAD_INDEX  = 3'd4,
    ST_BAD_TARGET = 3'd5
  } status_e;

  typedef struct packed {
    gate_e            kind;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
  } log_entry_t;

  typedef struct packed {
    action_e          action;
    gate_e            gate_kind;
    logic [IDX_W-1:0] index_a;
    logic [IDX_W-1:0] index_b;
    logic [IDX_W-1:0] index_c;
    logic [TGT_W-1:0] target_count;
  } in_item_t;

  typedef struct packed {
    logic [HC_W-1:0] history_count;
    logic            bit_a;
    logic            bit_b;
    logic            bit_c;
    status_e         status;
  } out_item_t;

  typedef struct packed {
    logic    load_item;
    logic    sel_item;
    logic    rd_c;
    logic    cap_ab;
    logic    wr_first;
    logic    wr_second;
    logic    exec_commit;
    logic    log_back;
    logic    log_fwd;
    logic    ent_from_log;
    logic    st_load;
    status_e st_val;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_e act;
    logic    bad_index;
    logic    log_full;
    logic    cnt_zero;
    logic    redo_empty;
    logic    bad_target;
    logic    at_target;
    logic    ent_swap;
    logic    out_free;
  } dp_stat_t;

endpackage

/* src/rgmu_if.sv */
`timescale 1ns / 1ps

interface rgmu_in_if;
  import rgmu_pkg::*;

  logic             valid;
  logic             ready;
  action_e          action;
  gate_e            gate_kind;
  logic [IDX_W-1:0] index_a;
  logic [IDX_W-1:0] index_b;
  logic [IDX_W-1:0] index_c;
  logic [TGT_W-1:0] target_count;

  modport source (
    output valid, action, gate_kind, index_a, index_b, index_c, target_count,
    input  ready
  );

  modport sink (
    input  valid, action, gate_kind, index_a, index_b, index_c, target_count,
    output ready
  );
endinterface

interface rgmu_out_if;
  import rgmu_pkg::*;

  logic            valid;
  logic            ready;
  logic [HC_W-1:0] history_count;
  logic            bit_a;
  logic            bit_b;
  logic            bit_c;
  status_e         status;

  modport source (
    output valid, history_count, bit_a, bit_b, bit_c, status,
    input  ready
  );

  modport sink (
    input  valid, history_count, bit_a, bit_b, bit_c, status,
    output ready
  );
endinterface

/* src/rgmu_ctrl.sv */
`timescale 1ns / 1ps

module rgmu_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rgmu_pkg::dp_stat_t stat_i,
  output rgmu_pkg::dp_cmd_t  cmd_o
);
  import rgmu_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CHECK = 11'b000_0000_0010,
    S_RWIND = 11'b000_0000_0100,
    S_LOAD  = 11'b000_0000_1000,
    S_A_AB  = 11'b000_0001_0000,
    S_A_C   = 11'b000_0010_0000,
    S_A_W1  = 11'b000_0100_0000,
    S_A_W2  = 11'b000_1000_0000,
    S_O_AB  = 11'b001_0000_0000,
    S_O_C   = 11'b010_0000_0000,
    S_O_OUT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  state_e after_apply;

  assign in_ready_o  = (state_q == S_IDLE);
  assign after_apply = (stat_i.act == ACT_RESTORE) ? S_RWIND : S_O_AB;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.st_load = 1'b1;
        cmd_o.st_val  = ST_OK;
        state_d       = S_O_AB;
        case (stat_i.act)
          ACT_EXEC: begin
            if (stat_i.bad_index) begin
              cmd_o.st_val = ST_BAD_INDEX;
            end else if (stat_i.log_full) begin
              cmd_o.st_val = ST_LOG_FULL;
            end else begin
              cmd_o.exec_commit = 1'b1;
              state_d           = S_A_AB;
            end
          end
          ACT_BACK: begin
            if (stat_i.cnt_zero) begin
              cmd_o.st_val = ST_NO_UNDO;
            end else begin
              cmd_o.log_back = 1'b1;
              state_d        = S_LOAD;
            end
          end
          ACT_FWD: begin
            if (stat_i.redo_empty) begin
              cmd_o.st_val = ST_NO_REDO;
            end else begin
              cmd_o.log_fwd = 1'b1;
              state_d       = S_LOAD;
            end
          end
          ACT_RESTORE: begin
            if (stat_i.bad_target) begin
              cmd_o.st_val = ST_BAD_TARGET;
            end else begin
              state_d = S_RWIND;
            end
          end
          default: begin
            state_d = S_O_AB;
          end
        endcase
      end
      S_RWIND: begin
        if (stat_i.at_target) begin
          state_d = S_O_AB;
        end else begin
          cmd_o.log_back = 1'b1;
          state_d        = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.ent_from_log = 1'b1;
        state_d            = S_A_AB;
      end
      S_A_AB: begin
        state_d = S_A_C;
      end
      S_A_C: begin
        cmd_o.rd_c   = 1'b1;
        cmd_o.cap_ab = 1'b1;
        state_d      = S_A_W1;
      end
      S_A_W1: begin
        cmd_o.wr_first = 1'b1;
        state_d        = stat_i.ent_swap ? S_A_W2 : after_apply;
      end
      S_A_W2: begin
        cmd_o.wr_second = 1'b1;
        state_d         = after_apply;
      end
      S_O_AB: begin
        cmd_o.sel_item = 1'b1;
        state_d        = S_O_C;
      end
      S_O_C: begin
        cmd_o.sel_item = 1'b1;
        cmd_o.rd_c     = 1'b1;
        cmd_o.cap_ab   = 1'b1;
        state_d        = S_O_OUT;
      end
      S_O_OUT: begin
        cmd_o.sel_item = 1'b1;
        cmd_o.rd_c     = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/rgmu_dp.sv */
`timescale 1ns / 1ps

module rgmu_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rgmu_pkg::LIM_W-1:0]     cfg_wdata_i,
  input  rgmu_pkg::in_item_t             item_i,
  input  rgmu_pkg::dp_cmd_t              cmd_i,
  output rgmu_pkg::dp_stat_t             stat_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output rgmu_pkg::out_item_t            out_o
);
  import rgmu_pkg::*;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] wide;
    wide = {1'b0, idx};
    return wide < (IDX_W + 1)'(NUM_BITS);
  endfunction

  logic [LIM_W-1:0] lim_q;
  logic [LIM_W-1:0] lim_eff;
  in_item_t         item_q;
  log_entry_t       ent_q;
  log_entry_t       item_ent;
  log_entry_t       src_ent;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] redo_q;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;
  status_e          st_q;
  logic             ra_q;
  logic             rb_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // bit store
  logic                bit_mem [NUM_BITS];
  logic [NUM_BITS-1:0] bit_vld_q;
  logic [IDX_W-1:0]    idx0;
  logic [IDX_W-1:0]    idx1;
  logic                rd0_q, rd1_q, rv0_q, rv1_q, rr0_q, rr1_q;
  logic                r0, r1;
  logic                bit_we;
  logic                bit_we_g;
  logic [IDX_W-1:0]    w_idx;
  logic                w_dat;

  // gate log
  log_entry_t        log_mem [LOG_DEPTH];
  log_entry_t        log_rdata_q;
  logic              log_re;
  logic [LOG_AW-1:0] log_raddr;

  logic ga, gb, gc;
  logic bad_index;
  logic log_full;

  assign item_ent = '{kind: item_q.gate_kind, a: item_q.index_a,
                      b: item_q.index_b, c: item_q.index_c};
  assign src_ent  = cmd_i.sel_item ? item_ent : ent_q;
  assign idx0     = cmd_i.rd_c ? src_ent.c : src_ent.a;
  assign idx1     = src_ent.b;
  assign cnt_inc  = count_q + CNT_W'(1);
  assign cnt_dec  = count_q - CNT_W'(1);

  assign lim_eff = (lim_q < LIM_W'(NUM_BITS)) ? lim_q : LIM_W'(NUM_BITS);
  assign ga = LIM_W'(item_q.index_a) >= lim_eff;
  assign gb = LIM_W'(item_q.index_b) >= lim_eff;
  assign gc = LIM_W'(item_q.index_c) >= lim_eff;

  always_comb begin
    case (item_q.gate_kind)
      GATE_CCNOT: bad_index = ga | gb | gc | (item_q.index_c == item_q.index_a) |
                              (item_q.index_c == item_q.index_b);
      GATE_CNOT:  bad_index = ga | gb | (item_q.index_a == item_q.index_b);
      GATE_NOT:   bad_index = ga;
      GATE_SWAP:  bad_index = ga | gb;
      default:    bad_index = ga;
    endcase
  end

  assign log_full = count_q >= CNT_W'(LOG_DEPTH);

  always_comb begin
    stat_o            = '0;
    stat_o.act        = item_q.action;
    stat_o.bad_index  = bad_index;
    stat_o.log_full   = log_full;
    stat_o.cnt_zero   = (count_q == '0);
    stat_o.redo_empty = (count_q >= redo_q) | log_full;
    stat_o.bad_target = CMP_W'(item_q.target_count) > CMP_W'(count_q);
    stat_o.at_target  = CMP_W'(item_q.target_count) == CMP_W'(count_q);
    stat_o.ent_swap   = (ent_q.kind == GATE_SWAP);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign r0 = rd0_q & rv0_q & rr0_q;
  assign r1 = rd1_q & rv1_q & rr1_q;

  // gate write port, second write only for swap
  always_comb begin
    bit_we = 1'b0;
    w_idx  = ent_q.a;
    w_dat  = 1'b0;
    if (cmd_i.wr_first) begin
      case (ent_q.kind)
        GATE_CCNOT: begin
          bit_we = ra_q & rb_q;
          w_idx  = ent_q.c;
          w_dat  = ~r0;
        end
        GATE_CNOT: begin
          bit_we = ra_q;
          w_idx  = ent_q.b;
          w_dat  = ~rb_q;
        end
        GATE_NOT: begin
          bit_we = 1'b1;
          w_idx  = ent_q.a;
          w_dat  = ~ra_q;
        end
        default: begin
          bit_we = 1'b1;
          w_idx  = ent_q.a;
          w_dat  = rb_q;
        end
      endcase
    end else if (cmd_i.wr_second) begin
      bit_we = 1'b1;
      w_idx  = ent_q.b;
      w_dat  = ra_q;
    end
  end

  assign bit_we_g = bit_we & in_range(w_idx);

  always_ff @(posedge clk_i) begin
    if (bit_we_g) begin
      bit_mem[w_idx[BIT_AW-1:0]] <= w_dat;
    end
    rd0_q <= bit_mem[idx0[BIT_AW-1:0]];
    rd1_q <= bit_mem[idx1[BIT_AW-1:0]];
    rv0_q <= bit_vld_q[idx0[BIT_AW-1:0]];
    rv1_q <= bit_vld_q[idx1[BIT_AW-1:0]];
    rr0_q <= in_range(idx0);
    rr1_q <= in_range(idx1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_vld_q <= '0;
    end else if (bit_we_g) begin
      bit_vld_q[w_idx[BIT_AW-1:0]] <= 1'b1;
    end
  end

  assign log_re    = cmd_i.log_back | cmd_i.log_fwd;
  assign log_raddr = cmd_i.log_back ? cnt_dec[LOG_AW-1:0] : count_q[LOG_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec_commit) begin
      log_mem[count_q[LOG_AW-1:0]] <= item_ent;
    end
    if (log_re) begin
      log_rdata_q <= log_mem[log_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= LIM_RESET;
      count_q     <= '0;
      redo_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_wdata_i;
      end
      if (cmd_i.exec_commit) begin
        count_q <= cnt_inc;
        redo_q  <= cnt_inc;
      end else if (cmd_i.log_back) begin
        count_q <= cnt_dec;
      end else if (cmd_i.log_fwd) begin
        count_q <= cnt_inc;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
    if (cmd_i.exec_commit) begin
      ent_q <= item_ent;
    end else if (cmd_i.ent_from_log) begin
      ent_q <= log_rdata_q;
    end
    if (cmd_i.st_load) begin
      st_q <= cmd_i.st_val;
    end
    if (cmd_i.cap_ab) begin
      ra_q <= r0;
      rb_q <= r1;
    end
    if (cmd_i.out_load) begin
      out_q <= '{history_count: HC_W'(count_q), bit_a: ra_q, bit_b: rb_q,
                 bit_c: r0, status: st_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

/* src/reversible_gate_machine_undo_unit.sv */
`timescale 1ns / 1ps

// Reversible gate machine with undo and redo over a log of up to 4096 gates on
// 256 bit registers. One item gives one result. An execute reads operands a and
// b, then c, then writes the target, twice for a swap; a step back or forward
// reads its log entry, a refused item applies nothing, and a restore rewinds
// one log entry at a time. These steps come from the single write port of the
// bit store, its registered read ports (operands a and b, then c) and the
// registered read of the log memory. A new item is accepted in the cycle after
// the result is registered, while that result still waits on the output side.
module reversible_gate_machine_undo_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rgmu_in_if.sink                    in_i,
  rgmu_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [rgmu_pkg::LIM_W-1:0] cfg_wdata_i
);
  import rgmu_pkg::*;

  in_item_t  item;
  out_item_t res;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      res_valid;

  assign item = '{action: in_i.action, gate_kind: in_i.gate_kind,
                  index_a: in_i.index_a, index_b: in_i.index_b,
                  index_c: in_i.index_c, target_count: in_i.target_count};

  rgmu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rgmu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (res_valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.valid         = res_valid;
  assign out_o.history_count = res.history_count;
  assign out_o.bit_a         = res.bit_a;
  assign out_o.bit_b         = res.bit_b;
  assign out_o.bit_c         = res.bit_c;
  assign out_o.status        = res.status;

endmodule

/* src/rgmu_checker.sv */
`timescale 1ns / 1ps

module rgmu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [rgmu_pkg::HC_W-1:0] history_count_i,
  input rgmu_pkg::status_e         status_i
);
  import rgmu_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(history_count_i) &&
                                    $stable(status_i))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while busy");

  // a result never shows in the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result too early");

endmodule

bind reversible_gate_machine_undo_unit rgmu_checker u_rgmu_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .history_count_i (out_o.history_count),
  .status_i        (out_o.status)
);

/* tb/sv/reversible_gate_machine_undo_unit_tb.sv */
`timescale 1ns / 1ps

module reversible_gate_machine_undo_unit_tb;
  import rgmu_pkg::*;

  localparam longint TIMEOUT_NS = 64_000_000;
  localparam int     DRAIN_CYCLES = 16;
  localparam int     HIST_CAP = 64;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LIM_W-1:0] cfg_wdata_i;

  rgmu_in_if  in_if ();
  rgmu_out_if out_if ();

  reversible_gate_machine_undo_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // mirror of the machine
  logic [NUM_BITS-1:0] bit_mirror;
  log_entry_t          gate_hist [LOG_DEPTH];
  int unsigned         applied_cnt;
  int unsigned         logged_cnt;
  int unsigned         lim_mirror;

  out_item_t outcome_q [$];

  int          tx_idle_pct;
  int          rx_stall_pct;
  logic        hold_rx;
  int          err_cnt;
  int          items_sent;
  int          checked_cnt;
  int unsigned deepest_hist;
  int          status_seen [8];

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic void flip_gate(input log_entry_t e);
    logic t;
    case (e.kind)
      GATE_CCNOT: if (bit_mirror[e.a] && bit_mirror[e.b]) bit_mirror[e.c] = ~bit_mirror[e.c];
      GATE_CNOT:  if (bit_mirror[e.a]) bit_mirror[e.b] = ~bit_mirror[e.b];
      GATE_NOT:   bit_mirror[e.a] = ~bit_mirror[e.a];
      default: begin
        t = bit_mirror[e.a];
        bit_mirror[e.a] = bit_mirror[e.b];
        bit_mirror[e.b] = t;
      end
    endcase
  endfunction

  function automatic int unsigned eff_limit();
    return (lim_mirror < NUM_BITS) ? lim_mirror : NUM_BITS;
  endfunction

  function automatic out_item_t step_machine(input in_item_t it);
    out_item_t   r;
    logic        bad;
    int unsigned lim;
    log_entry_t  e;
    lim = eff_limit();
    r.status = ST_OK;
    case (it.action)
      ACT_EXEC: begin
        case (it.gate_kind)
          GATE_CCNOT: bad = it.index_a >= lim || it.index_b >= lim || it.index_c >= lim ||
                            it.index_c == it.index_a || it.index_c == it.index_b;
          GATE_CNOT:  bad = it.index_a >= lim || it.index_b >= lim || it.index_a == it.index_b;
          GATE_NOT:   bad = it.index_a >= lim;
          default:    bad = it.index_a >= lim || it.index_b >= lim;
        endcase
        if (bad) begin
          r.status = ST_BAD_INDEX;
        end else if (applied_cnt >= LOG_DEPTH) begin
          r.status = ST_LOG_FULL;
        end else begin
          e.kind = it.gate_kind;
          e.a    = it.index_a;
          e.b    = it.index_b;
          e.c    = it.index_c;
          flip_gate(e);
          gate_hist[applied_cnt] = e;
          applied_cnt++;
          logged_cnt = applied_cnt;
        end
      end
      ACT_BACK: begin
        if (applied_cnt == 0) begin
          r.status = ST_NO_UNDO;
        end else begin
          applied_cnt--;
          flip_gate(gate_hist[applied_cnt]);
        end
      end
      ACT_FWD: begin
        if (applied_cnt >= logged_cnt || applied_cnt >= LOG_DEPTH) begin
          r.status = ST_NO_REDO;
        end else begin
          flip_gate(gate_hist[applied_cnt]);
          applied_cnt++;
        end
      end
      default: begin
        if (it.target_count > applied_cnt) begin
          r.status = ST_BAD_TARGET;
        end else begin
          while (applied_cnt > it.target_count) begin
            applied_cnt--;
            flip_gate(gate_hist[applied_cnt]);
          end
        end
      end
    endcase
    r.history_count = HC_W'(applied_cnt);
    r.bit_a = bit_mirror[it.index_a];
    r.bit_b = bit_mirror[it.index_b];
    r.bit_c = bit_mirror[it.index_c];
    return r;
  endfunction

  function automatic in_item_t op_item(input action_e act, input gate_e kind,
                                       input int unsigned a, input int unsigned b,
                                       input int unsigned c, input int unsigned tgt);
    in_item_t it;
    it.action       = act;
    it.gate_kind    = kind;
    it.index_a      = IDX_W'(a);
    it.index_b      = IDX_W'(b);
    it.index_c      = IDX_W'(c);
    it.target_count = TGT_W'(tgt);
    return it;
  endfunction

  // dense low indices keep controls set often, the rest spans the range
  function automatic int unsigned pick_idx(input int unsigned lim);
    if ($urandom_range(2) == 0) return $urandom_range(lim - 1);
    return $urandom_range(((lim < 6) ? lim : 6) - 1);
  endfunction

  function automatic in_item_t valid_exec_item();
    in_item_t    it;
    int unsigned lim;
    lim = eff_limit();
    it.action       = ACT_EXEC;
    it.gate_kind    = gate_e'($urandom_range(3));
    it.index_a      = IDX_W'($urandom);
    it.index_b      = IDX_W'($urandom);
    it.index_c      = IDX_W'($urandom);
    it.target_count = TGT_W'($urandom);
    case (it.gate_kind)
      GATE_CCNOT: begin
        it.index_c = IDX_W'(pick_idx(lim));
        it.index_a = IDX_W'(pick_idx(lim));
        it.index_b = IDX_W'(pick_idx(lim));
        if (it.index_a == it.index_c) it.index_a = IDX_W'((it.index_c + 1) % lim);
        if (it.index_b == it.index_c) it.index_b = IDX_W'((it.index_c + 1) % lim);
      end
      GATE_NOT: it.index_a = IDX_W'(pick_idx(lim));
      default: begin
        it.index_a = IDX_W'(pick_idx(lim));
        it.index_b = IDX_W'(pick_idx(lim));
        if (it.gate_kind == GATE_CNOT && it.index_b == it.index_a)
          it.index_b = IDX_W'((it.index_a + 1) % lim);
      end
    endcase
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(99);
    it = op_item(ACT_EXEC, gate_e'($urandom_range(3)), pick_idx(NUM_BITS),
                 pick_idx(NUM_BITS), pick_idx(NUM_BITS), $urandom);
    if (r < 45) it.action = ACT_EXEC;
    else if (r < 65) it.action = ACT_BACK;
    else if (r < 85) it.action = ACT_FWD;
    else it.action = ACT_RESTORE;
    if (applied_cnt >= HIST_CAP && (it.action == ACT_EXEC || it.action == ACT_FWD))
      it.action = ACT_BACK;
    if (it.action == ACT_EXEC && $urandom_range(9) != 0) it = valid_exec_item();
    if (it.action == ACT_RESTORE && $urandom_range(4) != 0)
      it.target_count = TGT_W'($urandom_range(applied_cnt));
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= 50)
      $display("mismatch at result %0d: %s got %0d expected %0d", checked_cnt, what, got, want);
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.action       <= it.action;
    in_if.gate_kind    <= it.gate_kind;
    in_if.index_a      <= it.index_a;
    in_if.index_b      <= it.index_b;
    in_if.index_c      <= it.index_c;
    in_if.target_count <= it.target_count;
    do @(posedge clk_i); while (!in_if.ready);
    outcome_q.push_back(step_machine(it));
    items_sent++;
    if (applied_cnt > deepest_hist) deepest_hist = applied_cnt;
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bits_in_use(input int unsigned v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LIM_W'(v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    lim_mirror = v & 'h1FF;
  endtask

  task automatic test_directed_ops();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_item(op_item(ACT_BACK,    GATE_CCNOT, 0, 0, 0, 0));
    send_item(op_item(ACT_FWD,     GATE_CCNOT, 0, 0, 0, 0));
    send_item(op_item(ACT_RESTORE, GATE_CCNOT, 0, 0, 0, 0));
    send_item(op_item(ACT_RESTORE, GATE_CCNOT, 0, 0, 0, 1));
    send_item(op_item(ACT_EXEC,    GATE_NOT,   0, 0, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_NOT,   255, 255, 255, 0));
    send_item(op_item(ACT_EXEC,    GATE_CNOT,  0, 255, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_CNOT,  3, 3, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_CCNOT, 0, 0, 7, 0));
    send_item(op_item(ACT_EXEC,    GATE_CCNOT, 0, 5, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_CCNOT, 5, 0, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_SWAP,  7, 128, 7, 0));
    send_item(op_item(ACT_EXEC,    GATE_SWAP,  9, 9, 128, 0));
    send_item(op_item(ACT_BACK,    GATE_SWAP,  7, 128, 9, 0));
    send_item(op_item(ACT_BACK,    GATE_SWAP,  7, 128, 9, 0));
    send_item(op_item(ACT_FWD,     GATE_SWAP,  7, 128, 9, 0));
    send_item(op_item(ACT_FWD,     GATE_SWAP,  7, 128, 9, 0));
    send_item(op_item(ACT_FWD,     GATE_SWAP,  7, 128, 9, 0));
    send_item(op_item(ACT_RESTORE, GATE_SWAP,  0, 7, 255, 2));
    send_item(op_item(ACT_EXEC,    GATE_NOT,   1, 0, 7, 0));
    send_item(op_item(ACT_FWD,     GATE_NOT,   1, 0, 7, 0));
    send_item(op_item(ACT_RESTORE, GATE_NOT,   1, 0, 7, 8191));
    send_item(op_item(ACT_RESTORE, GATE_NOT,   1, 0, 255, 0));
    wait_idle();
  endtask

  task automatic test_bits_in_use();
    send_item(op_item(ACT_EXEC,    GATE_NOT,   200, 0, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_SWAP,  200, 3, 0, 0));
    wait_idle();
    write_bits_in_use(1);
    send_item(op_item(ACT_EXEC,    GATE_NOT,   0, 255, 255, 0));
    send_item(op_item(ACT_EXEC,    GATE_NOT,   1, 0, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_CNOT,  0, 1, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_SWAP,  0, 0, 200, 0));
    send_item(op_item(ACT_EXEC,    GATE_CCNOT, 0, 0, 0, 0));
    send_item(op_item(ACT_BACK,    GATE_NOT,   0, 3, 200, 0));
    send_item(op_item(ACT_RESTORE, GATE_NOT,   0, 3, 200, 0));
    send_item(op_item(ACT_FWD,     GATE_NOT,   0, 3, 200, 0));
    send_item(op_item(ACT_FWD,     GATE_NOT,   0, 3, 200, 0));
    wait_idle();
    write_bits_in_use(2);
    send_item(op_item(ACT_EXEC,    GATE_CNOT,  0, 1, 255, 0));
    send_item(op_item(ACT_EXEC,    GATE_CCNOT, 1, 1, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_CCNOT, 0, 1, 2, 0));
    send_item(op_item(ACT_EXEC,    GATE_SWAP,  1, 2, 0, 0));
    send_item(op_item(ACT_RESTORE, GATE_SWAP,  0, 1, 200, 0));
    wait_idle();
  endtask

  task automatic test_random_phase(input int tx, input int rx, input int unsigned lim,
                                   input int n);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    write_bits_in_use(lim);
    repeat (n) send_item(random_item());
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_bits_in_use(NUM_BITS);
    fork
      begin
        hold_rx <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    repeat (12) send_item(random_item());
    wait_idle();
  endtask

  task automatic test_full_log();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_bits_in_use(NUM_BITS);
    send_item(op_item(ACT_RESTORE, GATE_NOT, 0, 0, 0, 0));
    while (applied_cnt < LOG_DEPTH) send_item(valid_exec_item());
    send_item(op_item(ACT_EXEC,    GATE_NOT,  5, 0, 0, 0));
    send_item(op_item(ACT_EXEC,    GATE_CNOT, 9, 9, 0, 0));
    send_item(op_item(ACT_FWD,     GATE_NOT,  0, 1, 2, 0));
    send_item(op_item(ACT_RESTORE, GATE_NOT,  0, 1, 2, LOG_DEPTH));
    send_item(op_item(ACT_RESTORE, GATE_NOT,  0, 1, 2, LOG_DEPTH + 1));
    send_item(op_item(ACT_BACK,    GATE_NOT,  0, 1, 2, 0));
    send_item(op_item(ACT_FWD,     GATE_NOT,  0, 1, 2, 0));
    send_item(op_item(ACT_RESTORE, GATE_NOT,  0, 1, 2, 0));
    wait_idle();
  endtask

  always @(posedge clk_i) begin
    if (hold_rx) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with nothing pending, history_count",
                        int'(out_if.history_count), 0);
      end else begin
        want = outcome_q.pop_front();
        checked_cnt++;
        status_seen[want.status]++;
        if (out_if.history_count !== want.history_count)
          report_mismatch("history_count", int'(out_if.history_count),
                          int'(want.history_count));
        if (out_if.bit_a !== want.bit_a)
          report_mismatch("bit_a", int'(out_if.bit_a), int'(want.bit_a));
        if (out_if.bit_b !== want.bit_b)
          report_mismatch("bit_b", int'(out_if.bit_b), int'(want.bit_b));
        if (out_if.bit_c !== want.bit_c)
          report_mismatch("bit_c", int'(out_if.bit_c), int'(want.bit_c));
        if (out_if.status !== want.status)
          report_mismatch("status", int'(out_if.status), int'(want.status));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("run timed out with %0d results pending", outcome_q.size());
    $display("reversible_gate_machine_undo_unit_tb failed");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = LIM_RESET;
    in_if.valid        = 1'b0;
    in_if.action       = ACT_EXEC;
    in_if.gate_kind    = GATE_CCNOT;
    in_if.index_a      = '0;
    in_if.index_b      = '0;
    in_if.index_c      = '0;
    in_if.target_count = '0;
    out_if.ready       = 1'b0;
    hold_rx            = 1'b0;
    tx_idle_pct        = 0;
    rx_stall_pct       = 0;
    err_cnt            = 0;
    items_sent         = 0;
    checked_cnt        = 0;
    deepest_hist       = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    bit_mirror         = '0;
    applied_cnt        = 0;
    logged_cnt         = 0;
    lim_mirror         = NUM_BITS;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_bits_in_use();
    test_random_phase(0, 0, NUM_BITS, 300);
    test_random_phase(49, 0, $urandom_range(3, 64), 300);
    test_random_phase(0, 49, 17, 300);
    test_random_phase(6, 6, $urandom_range(1, NUM_BITS), 300);
    test_backpressure();
    test_full_log();

    if (outcome_q.size() != 0)
      report_mismatch("results never delivered", outcome_q.size(), 0);
    $display("%0d items sent, %0d results checked, history reached %0d of %0d entries",
             items_sent, checked_cnt, deepest_hist, LOG_DEPTH);
    $display("statuses: ok %0d, log full %0d, no undo %0d, no redo %0d, bad index %0d, %s %0d",
             status_seen[ST_OK], status_seen[ST_LOG_FULL], status_seen[ST_NO_UNDO],
             status_seen[ST_NO_REDO], status_seen[ST_BAD_INDEX], "bad target",
             status_seen[ST_BAD_TARGET]);
    if (err_cnt == 0) begin
      $display("reversible_gate_machine_undo_unit_tb passed");
    end else begin
      $display("reversible_gate_machine_undo_unit_tb failed");
    end
    $finish;
  end

endmodule
